FILE: rtl/stereo_dac_beeper_mixer_unit_macros.svh
// Assertion macros shared by the RTL of the stereo DAC and beeper mixer.
// Defining ASSERT_OFF removes every assertion.
`ifndef STEREO_DAC_BEEPER_MIXER_UNIT_MACROS_SVH
`define STEREO_DAC_BEEPER_MIXER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge, including while reset is applied.
`define SDBM_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

// Checked at every rising edge outside of reset.
`define SDBM_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

`else

`define SDBM_ASSERT(lbl, clk, prop)
`define SDBM_ASSERT_RST(lbl, clk, rst, prop)

`endif

`endif

FILE: rtl/sdbm_pkg.sv
package sdbm_pkg;

   // Default sample buffer capacity.
   localparam int SampleCapacityDefault = 1024;

   // Largest value the 11-bit sample count can hold.
   localparam int SampleCountMax = 2047;

   // Samples per frame at 60 Hz and 50 Hz.
   localparam logic [15:0] FrameSamples60 = 16'd800;
   localparam logic [15:0] FrameSamples50 = 16'd960;

   // Operation codes.
   localparam logic [1:0] ModeWrite = 2'd0;
   localparam logic [1:0] ModeRead  = 2'd1;
   localparam logic [1:0] ModeMix   = 2'd2;

   // Register addresses.
   localparam logic [7:0] RegSound   = 8'h00;
   localparam logic [7:0] RegAudio   = 8'h08;
   localparam logic [7:0] RegMono    = 8'h09;
   localparam logic [7:0] RegDacB    = 8'h2c;
   localparam logic [7:0] RegDacAD   = 8'h2d;
   localparam logic [7:0] RegDacC    = 8'h2e;

   // Mid-scale DAC value.
   localparam logic [7:0] DacMid = 8'h80;

   // Beeper contributions.
   localparam logic [12:0] EarLevel = 13'(512 * 12);
   localparam logic [12:0] MicLevel = 13'(128 * 12);

   // Reciprocal of 3 scaled by 2^17, exact for 15-bit dividends.
   localparam logic [15:0] RecipThree = 16'hAAAB;
   localparam int          RecipShift = 17;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  reg_index;
      logic [7:0]  write_data;
      logic        ear_bit;
      logic        mic_bit;
      logic [17:0] psg_level_left;
      logic [17:0] psg_level_right;
      logic [15:0] request_count;
   } req_type;

   typedef struct packed {
      logic               read_valid;
      logic [7:0]         read_byte;
      logic               dac_written;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [10:0]        sample_count;
   } rsp_type;

   // Register state the mixer needs.
   typedef struct packed {
      logic [3:0][7:0] dac_channel;
      logic            beeper_muted;
      logic            dacs_enable;
      logic            hdmi_silence;
   } mix_state_type;

   // Outcome of a register access.
   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
      logic       dac_written;
   } reg_result_type;

   // Outcome of a mix.
   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [10:0]        sample_count;
   } mix_result_type;

endpackage

FILE: rtl/sdbm_regfile.sv
`include "stereo_dac_beeper_mixer_unit_macros.svh"

module sdbm_regfile
   import sdbm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           access_en,
   input  req_type        req,
   output reg_result_type result,
   output mix_state_type  mix_state
);

   logic [3:0][7:0] dac_ff, dac_in;
   logic            beep_internal_only_ff, beep_internal_only_in;
   logic [1:0]      psg_mode_bits_ff, psg_mode_bits_in;
   logic            ay_stereo_ff, ay_stereo_in;
   logic            speaker_enable_ff, speaker_enable_in;
   logic            dacs_enable_ff, dacs_enable_in;
   logic            hdmi_silence_ff, hdmi_silence_in;
   logic            turbo_enable_ff, turbo_enable_in;
   logic [2:0]      ay_mono_bits_ff, ay_mono_bits_in;

   // Decode the access: next register values and the read or write outcome.
   always_comb begin
      dac_in                = dac_ff;
      beep_internal_only_in = beep_internal_only_ff;
      psg_mode_bits_in      = psg_mode_bits_ff;
      ay_stereo_in          = ay_stereo_ff;
      speaker_enable_in     = speaker_enable_ff;
      dacs_enable_in        = dacs_enable_ff;
      hdmi_silence_in       = hdmi_silence_ff;
      turbo_enable_in       = turbo_enable_ff;
      ay_mono_bits_in       = ay_mono_bits_ff;
      result                = '0;

      if (req.mode == ModeWrite) begin
         unique case (req.reg_index)
            RegSound: begin
               beep_internal_only_in = req.write_data[6];
               psg_mode_bits_in      = req.write_data[1:0];
            end
            RegAudio: begin
               ay_stereo_in      = req.write_data[5];
               speaker_enable_in = req.write_data[4];
               dacs_enable_in    = req.write_data[3];
               hdmi_silence_in   = req.write_data[2];
               turbo_enable_in   = req.write_data[1];
               // Disabling the DACs parks every channel at mid-scale.
               if (!req.write_data[3]) begin
                  dac_in = {4{DacMid}};
               end
            end
            RegMono: begin
               ay_mono_bits_in = req.write_data[7:5];
            end
            RegDacB: begin
               dac_in[1]          = req.write_data;
               result.dac_written = 1'b1;
            end
            RegDacAD: begin
               dac_in[0]          = req.write_data;
               dac_in[3]          = req.write_data;
               result.dac_written = 1'b1;
            end
            RegDacC: begin
               dac_in[2]          = req.write_data;
               result.dac_written = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (req.mode == ModeRead) begin
         unique case (req.reg_index)
            RegDacB: begin
               result.read_valid = 1'b1;
               result.read_byte  = dac_ff[1];
            end
            RegDacAD: begin
               result.read_valid = 1'b1;
               result.read_byte  = dac_ff[0];
            end
            RegDacC: begin
               result.read_valid = 1'b1;
               result.read_byte  = dac_ff[2];
            end
            default: begin
            end
         endcase
      end
   end

   // Register state, updated only when the item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         dac_ff                <= {4{DacMid}};
         beep_internal_only_ff <= 1'b0;
         psg_mode_bits_ff      <= '0;
         ay_stereo_ff          <= 1'b0;
         speaker_enable_ff     <= 1'b1;
         dacs_enable_ff        <= 1'b1;
         hdmi_silence_ff       <= 1'b0;
         turbo_enable_ff       <= 1'b1;
         ay_mono_bits_ff       <= '0;
      end else if (access_en) begin
         dac_ff                <= dac_in;
         beep_internal_only_ff <= beep_internal_only_in;
         psg_mode_bits_ff      <= psg_mode_bits_in;
         ay_stereo_ff          <= ay_stereo_in;
         speaker_enable_ff     <= speaker_enable_in;
         dacs_enable_ff        <= dacs_enable_in;
         hdmi_silence_ff       <= hdmi_silence_in;
         turbo_enable_ff       <= turbo_enable_in;
         ay_mono_bits_ff       <= ay_mono_bits_in;
      end
   end

   // The beeper is muted when it is routed internally with the speaker on.
   assign mix_state.dac_channel  = dac_ff;
   assign mix_state.beeper_muted = beep_internal_only_ff && speaker_enable_ff;
   assign mix_state.dacs_enable  = dacs_enable_ff;
   assign mix_state.hdmi_silence = hdmi_silence_ff;

   `SDBM_ASSERT_RST(a_dac_disable_parks, clock, reset,
      access_en && req.mode == ModeWrite && req.reg_index == RegAudio
      && !req.write_data[3] |=> dac_ff == {4{DacMid}})
   `SDBM_ASSERT_RST(a_dac_holds_when_idle, clock, reset,
      !access_en |=> $stable(dac_ff))

endmodule

FILE: rtl/sdbm_mixer.sv
module sdbm_mixer
   import sdbm_pkg::*;
#(
   parameter int SAMPLE_CAPACITY = SampleCapacityDefault
)(
   input  req_type        req,
   input  mix_state_type  mix_state,
   input  logic           frame_rate_60hz,
   output mix_result_type result
);

   // The count is capped by the buffer and by the width of its field.
   localparam int CountLimitInt =
      (SAMPLE_CAPACITY > SampleCountMax) ? SampleCountMax : SAMPLE_CAPACITY;
   localparam logic [15:0] CountLimit = 16'(CountLimitInt);

   // Scale by 11, halve toward minus infinity and saturate to 16 bits.
   function automatic logic signed [15:0] mix_out(input logic signed [16:0] sum);
      logic signed [20:0] sum_ext;
      logic signed [20:0] scaled;
      logic signed [20:0] halved;
      sum_ext = {{4{sum[16]}}, sum};
      scaled  = (sum_ext <<< 3) + (sum_ext <<< 1) + sum_ext;
      halved  = scaled >>> 1;
      if (halved > 21'sd32767) begin
         return 16'sh7FFF;
      end else if (halved < -21'sd32768) begin
         return 16'sh8000;
      end else begin
         return halved[15:0];
      end
   endfunction

   logic [30:0]        psg_prod_l, psg_prod_r;
   logic [13:0]        psg_l, psg_r, psg_peak;
   logic [12:0]        psg_mid;
   logic [13:0]        psg_term_l, psg_term_r;
   logic [12:0]        beep_level;
   logic [8:0]         dac_pair_l, dac_pair_r;
   logic signed [11:0] dac_term_l, dac_term_r;
   logic signed [16:0] sum_l, sum_r;
   logic [15:0]        count_req, count_capped;

   // PSG level divided by 24: drop three bits, then divide by 3 by reciprocal.
   assign psg_prod_l = 31'(req.psg_level_left[17:3]) * 31'(RecipThree);
   assign psg_prod_r = 31'(req.psg_level_right[17:3]) * 31'(RecipThree);
   assign psg_l      = psg_prod_l[RecipShift +: 14];
   assign psg_r      = psg_prod_r[RecipShift +: 14];

   // Center the PSG levels on half the louder side. The quieter side can go
   // negative, so each term is a two's complement value.
   assign psg_peak   = (psg_l > psg_r) ? psg_l : psg_r;
   assign psg_mid    = psg_peak[13:1];
   assign psg_term_l = psg_l - {1'b0, psg_mid};
   assign psg_term_r = psg_r - {1'b0, psg_mid};

   // Beeper ear and mic levels.
   assign beep_level = ((req.ear_bit && !mix_state.beeper_muted) ? EarLevel : '0)
                     + ((req.mic_bit && !mix_state.beeper_muted) ? MicLevel : '0);

   // DAC pairs, offset so that mid-scale gives zero.
   assign dac_pair_l = {1'b0, mix_state.dac_channel[0]} + {1'b0, mix_state.dac_channel[1]};
   assign dac_pair_r = {1'b0, mix_state.dac_channel[2]} + {1'b0, mix_state.dac_channel[3]};
   assign dac_term_l = mix_state.dacs_enable
                     ? $signed({1'b0, dac_pair_l, 2'b00}) - 12'sd1024 : '0;
   assign dac_term_r = mix_state.dacs_enable
                     ? $signed({1'b0, dac_pair_r, 2'b00}) - 12'sd1024 : '0;

   // Sum of all sources per side.
   assign sum_l = $signed({4'b0000, beep_level})
                + $signed({{3{psg_term_l[13]}}, psg_term_l})
                + $signed({{5{dac_term_l[11]}}, dac_term_l});
   assign sum_r = $signed({4'b0000, beep_level})
                + $signed({{3{psg_term_r[13]}}, psg_term_r})
                + $signed({{5{dac_term_r[11]}}, dac_term_r});

   // Sample count: a frame's worth when none is given, then capped.
   assign count_req    = (req.request_count == '0)
                       ? (frame_rate_60hz ? FrameSamples60 : FrameSamples50)
                       : req.request_count;
   assign count_capped = (count_req > CountLimit) ? CountLimit : count_req;

   assign result.left_sample  = mix_state.hdmi_silence ? '0 : mix_out(sum_l);
   assign result.right_sample = mix_state.hdmi_silence ? '0 : mix_out(sum_r);
   assign result.sample_count = count_capped[10:0];

endmodule

FILE: rtl/stereo_dac_beeper_mixer_unit.sv
// Audio register file and stereo mixer. Each item is a register write, a DAC
// register read or a request for one mixed stereo sample; every item gives
// exactly one result. Items are taken at one per clock. Each accepted item
// lands in an input register; the register decode and the mixing arithmetic
// (one 15x16 multiply for the PSG scaling, then the sum, scale and
// saturation) sit between that input register and
// the result register. A waiting result does not block the input register,
// so the rate stays at one item per cycle until both registers are full and
// rsp_stall is held. Register state changes as an item moves into the result
// register, so an item sees every write made by the items before it.
// SAMPLE_CAPACITY caps the reported sample count. frame_rate_60hz is written
// through the csr_ port and may change only while no item is in flight.
`include "stereo_dac_beeper_mixer_unit_macros.svh"

module stereo_dac_beeper_mixer_unit
   import sdbm_pkg::*;
#(
   parameter int SAMPLE_CAPACITY = SampleCapacityDefault
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic           in_valid_ff, in_valid_in;
   req_type        in_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;
   logic           frame_rate_60hz_ff;
   logic [10:0]    last_count_ff;
   logic           out_free;
   logic           advance;
   logic           accept;
   reg_result_type reg_result;
   mix_state_type  mix_state;
   mix_result_type mix_result;

   // Handshake: the input register moves on whenever the result register
   // is empty or its item is being taken.
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = req_stall ? 1'b1 : req_valid;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   sdbm_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .access_en (advance),
      .req       (in_ff),
      .result    (reg_result),
      .mix_state (mix_state)
   );

   sdbm_mixer #(
      .SAMPLE_CAPACITY (SAMPLE_CAPACITY)
   ) u_mixer (
      .req             (in_ff),
      .mix_state       (mix_state),
      .frame_rate_60hz (frame_rate_60hz_ff),
      .result          (mix_result)
   );

   // Assemble the result item; fields outside the operation stay zero.
   always_comb begin
      out_in             = '0;
      out_in.read_valid  = reg_result.read_valid;
      out_in.read_byte   = reg_result.read_byte;
      out_in.dac_written = reg_result.dac_written;
      if (in_ff.mode == ModeMix) begin
         out_in.left_sample  = mix_result.left_sample;
         out_in.right_sample = mix_result.right_sample;
         out_in.sample_count = mix_result.sample_count;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         frame_rate_60hz_ff <= 1'b0;
         last_count_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            frame_rate_60hz_ff <= csr_write_data;
         end
         if (advance && in_ff.mode == ModeMix) begin
            last_count_ff <= mix_result.sample_count;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `SDBM_ASSERT(a_stall_needs_item, clock,
      req_stall |-> in_valid_ff)
   `SDBM_ASSERT_RST(a_advance_fills_output, clock, reset,
      advance |=> out_valid_ff)
   `SDBM_ASSERT_RST(a_register_result_has_no_mix, clock, reset,
      out_valid_ff && (out_ff.read_valid || out_ff.dac_written)
      |-> out_ff.sample_count == '0 && out_ff.left_sample == '0
      && out_ff.right_sample == '0)

endmodule

FILE: sim/stereo_dac_beeper_mixer_unit_tb.sv
`timescale 1ns / 1ps

module stereo_dac_beeper_mixer_unit_tb;
   import sdbm_pkg::*;

   // Mode code that the block must ignore.
   localparam logic [1:0] ModeNone = 2'd3;

   localparam int Capacity    = SampleCapacityDefault;
   localparam int PsgDivisor  = 24;
   localparam int DacPairBias = 1024;
   localparam int MixGain     = 11;
   localparam int SampleHigh  = 32767;
   localparam int SampleLow   = -32768;
   localparam int StallLimit  = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;

   // Items waiting to be driven and results waiting to be seen.
   req_type item_backlog[$];
   rsp_type pending_results[$];

   int items_queued = 0;
   int results_checked = 0;
   int failures = 0;
   int idle_cycles = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_hold = 0;
   int rsp_calm = 0;
   logic req_taken = 1'b0;
   rsp_type want;

   // Mirror of the audio registers.
   logic [7:0] dac_level [4];
   logic       beeper_internal;
   logic [1:0] psg_mode;
   logic       ay_stereo_on;
   logic       speaker_on;
   logic       dacs_on;
   logic       hdmi_mute;
   logic       turbo_on;
   logic [2:0] mono_bits;
   logic [10:0] count_last;
   logic       frame_60;

   stereo_dac_beeper_mixer_unit #(
      .SAMPLE_CAPACITY(Capacity)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Scale by the mix gain, halve toward minus infinity and clip to 16 bits.
   function automatic logic signed [15:0] scale_and_clip(int sum);
      int v;
      v = (sum * MixGain) >>> 1;
      if (v > SampleHigh) v = SampleHigh;
      if (v < SampleLow) v = SampleLow;
      return 16'(v);
   endfunction

   // Apply one item to the register mirror and return the result it gives.
   function automatic rsp_type apply_audio_item(req_type it);
      rsp_type res;
      int count;
      int ear;
      int mic;
      int pl;
      int pr;
      int mid;
      int dl;
      int dr;
      int k;
      logic muted;
      res = '0;
      case (it.mode)
         ModeWrite: begin
            case (it.reg_index)
               RegSound: begin
                  beeper_internal = it.write_data[6];
                  psg_mode = it.write_data[1:0];
               end
               RegAudio: begin
                  ay_stereo_on = it.write_data[5];
                  speaker_on = it.write_data[4];
                  dacs_on = it.write_data[3];
                  hdmi_mute = it.write_data[2];
                  turbo_on = it.write_data[1];
                  // Turning the DACs off parks every channel at mid-scale.
                  if (!it.write_data[3]) begin
                     for (k = 0; k < 4; k++) dac_level[k] = DacMid;
                  end
               end
               RegMono: mono_bits = it.write_data[7:5];
               RegDacB: begin
                  dac_level[1] = it.write_data;
                  res.dac_written = 1'b1;
               end
               RegDacAD: begin
                  dac_level[0] = it.write_data;
                  dac_level[3] = it.write_data;
                  res.dac_written = 1'b1;
               end
               RegDacC: begin
                  dac_level[2] = it.write_data;
                  res.dac_written = 1'b1;
               end
               default: ;
            endcase
         end
         ModeRead: begin
            case (it.reg_index)
               RegDacB: begin
                  res.read_valid = 1'b1;
                  res.read_byte = dac_level[1];
               end
               RegDacAD: begin
                  res.read_valid = 1'b1;
                  res.read_byte = dac_level[0];
               end
               RegDacC: begin
                  res.read_valid = 1'b1;
                  res.read_byte = dac_level[2];
               end
               default: ;
            endcase
         end
         ModeMix: begin
            muted = beeper_internal && speaker_on;
            ear = (!muted && it.ear_bit) ? int'(EarLevel) : 0;
            mic = (!muted && it.mic_bit) ? int'(MicLevel) : 0;
            pl = int'(it.psg_level_left) / PsgDivisor;
            pr = int'(it.psg_level_right) / PsgDivisor;
            mid = ((pl > pr) ? pl : pr) / 2;
            dl = 0;
            dr = 0;
            if (dacs_on) begin
               dl = (int'(dac_level[0]) + int'(dac_level[1])) * 4 - DacPairBias;
               dr = (int'(dac_level[2]) + int'(dac_level[3])) * 4 - DacPairBias;
            end
            // A zero count asks for one frame; then the buffer size caps it.
            count = int'(it.request_count);
            if (count == 0) count = frame_60 ? int'(FrameSamples60) : int'(FrameSamples50);
            if (count > Capacity) count = Capacity;
            if (count > SampleCountMax) count = SampleCountMax;
            count_last = 11'(count);
            if (!hdmi_mute) begin
               res.left_sample = scale_and_clip(ear + mic + pl - mid + dl);
               res.right_sample = scale_and_clip(ear + mic + pr - mid + dr);
            end
            res.sample_count = 11'(count);
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   // Gap length: mostly none or short, a few long, with calm stretches.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) calm = $urandom_range(30, 120);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_item(logic [1:0] mode, logic [7:0] idx, logic [7:0] data);
      req_type it;
      it = '0;
      it.mode = mode;
      it.reg_index = idx;
      it.write_data = data;
      return it;
   endfunction

   function automatic req_type make_mix(logic ear, logic mic, logic [17:0] pl, logic [17:0] pr,
                                        logic [15:0] count);
      req_type it;
      it = make_item(ModeMix, '0, '0);
      it.ear_bit = ear;
      it.mic_bit = mic;
      it.psg_level_left = pl;
      it.psg_level_right = pr;
      it.request_count = count;
      return it;
   endfunction

   function automatic logic [17:0] psg_level();
      case ($urandom_range(0, 3))
         0: return 18'($urandom);
         1: return 18'($urandom_range(0, 4095));
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // Mostly mapped registers and well-formed mixes, with some noise.
   function automatic req_type random_item();
      req_type it;
      logic [95:0] raw;
      int r;
      raw = {$urandom, $urandom, $urandom};
      it = raw[71:0];
      r = $urandom_range(0, 99);
      if (r < 3) begin
         it.mode = ModeNone;
      end else if (r < 38) begin
         it.mode = ModeWrite;
         if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 5))
               0: it.reg_index = RegSound;
               1: it.reg_index = RegAudio;
               2: it.reg_index = RegMono;
               3: it.reg_index = RegDacB;
               4: it.reg_index = RegDacAD;
               default: it.reg_index = RegDacC;
            endcase
         end
         // Keep the DACs on and the output unmuted most of the time.
         if (it.reg_index == RegAudio) begin
            it.write_data[3] = ($urandom_range(0, 9) != 0);
            it.write_data[2] = ($urandom_range(0, 9) == 0);
         end
      end else if (r < 58) begin
         it.mode = ModeRead;
         if ($urandom_range(0, 99) < 80) begin
            case ($urandom_range(0, 2))
               0: it.reg_index = RegDacB;
               1: it.reg_index = RegDacAD;
               default: it.reg_index = RegDacC;
            endcase
         end
      end else begin
         it.mode = ModeMix;
         it.psg_level_left = psg_level();
         it.psg_level_right = psg_level();
         case ($urandom_range(0, 4))
            0: it.request_count = '0;
            1: it.request_count = 16'($urandom_range(1, 1024));
            2: it.request_count = 16'($urandom_range(1025, 2100));
            default: ;
         endcase
      end
      return it;
   endfunction

   task automatic queue_item(req_type it);
      item_backlog.push_back(it);
      items_queued++;
   endtask

   // Change the frame rate once every outstanding item has finished.
   task automatic set_frame_rate(logic rate_60);
      wait (results_checked == items_queued);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= rate_60;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Request side: present items from the backlog with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (item_backlog.size() != 0) begin
            req_data <= item_backlog.pop_front();
            req_valid <= 1'b1;
            req_gap = pick_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: stall at random.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
         rsp_hold = pick_gap(rsp_calm);
      end
   end

   // Predict each accepted item, check each accepted result, watch for a hang.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
         for (int k = 0; k < 4; k++) dac_level[k] = DacMid;
         beeper_internal = 1'b0;
         psg_mode = '0;
         ay_stereo_on = 1'b0;
         speaker_on = 1'b1;
         dacs_on = 1'b1;
         hdmi_mute = 1'b0;
         turbo_on = 1'b1;
         mono_bits = '0;
         count_last = '0;
         frame_60 = 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_write_enable) frame_60 = csr_write_data;
         if (req_valid && !req_stall) pending_results.push_back(apply_audio_item(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result with no item outstanding");
               failures++;
            end else begin
               want = pending_results.pop_front();
               compare_field("read_valid", want.read_valid, rsp_data.read_valid);
               compare_field("read_byte", want.read_byte, rsp_data.read_byte);
               compare_field("dac_written", want.dac_written, rsp_data.dac_written);
               compare_field("left_sample", want.left_sample, rsp_data.left_sample);
               compare_field("right_sample", want.right_sample, rsp_data.right_sample);
               compare_field("sample_count", want.sample_count, rsp_data.sample_count);
               results_checked++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= StallLimit) begin
            $display("stereo_dac_beeper_mixer_unit verification failed");
            $finish;
         end
      end
   end

   // Stimulus: directed cases at 50 Hz, then random phases over both rates.
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      set_frame_rate(1'b0);

      // DAC channels read back mid-scale after reset, then what was written.
      queue_item(make_item(ModeRead, RegDacB, '0));
      queue_item(make_item(ModeRead, RegDacAD, '0));
      queue_item(make_item(ModeRead, RegDacC, '0));
      queue_item(make_item(ModeWrite, RegDacB, 8'hff));
      queue_item(make_item(ModeWrite, RegDacAD, 8'h00));
      queue_item(make_item(ModeWrite, RegDacC, 8'h5a));
      queue_item(make_item(ModeRead, RegDacB, '0));
      queue_item(make_item(ModeRead, RegDacAD, '0));
      queue_item(make_item(ModeRead, RegDacC, '0));

      // Saturation at the top and the count cap.
      queue_item(make_mix(1'b1, 1'b1, '1, '1, 16'hffff));
      queue_item(make_mix(1'b0, 1'b0, '0, '1, 16'd1024));

      // Beeper kept internal while the speaker is on, then speaker off.
      queue_item(make_item(ModeWrite, RegSound, 8'h40));
      queue_item(make_mix(1'b1, 1'b1, 18'd1000, 18'd2000, 16'd1025));
      queue_item(make_item(ModeWrite, RegAudio, 8'h0a));
      queue_item(make_mix(1'b1, 1'b1, 18'd1000, 18'd2000, 16'd1));

      // DACs off: channels park at mid-scale, writes still land.
      queue_item(make_item(ModeWrite, RegAudio, 8'h00));
      queue_item(make_item(ModeRead, RegDacAD, '0));
      queue_item(make_mix(1'b0, 1'b1, 18'd77777, 18'd123, 16'd500));
      queue_item(make_item(ModeWrite, RegDacB, 8'h33));
      queue_item(make_item(ModeRead, RegDacB, '0));

      // Silenced output still reports its count.
      queue_item(make_item(ModeWrite, RegAudio, 8'h1c));
      queue_item(make_mix(1'b1, 1'b0, '1, 18'd5, 16'd0));

      // Mono bits, unmapped write and read, and the ignored mode.
      queue_item(make_item(ModeWrite, RegMono, 8'he0));
      queue_item(make_item(ModeWrite, 8'h01, 8'h77));
      queue_item(make_item(ModeRead, 8'hff, '0));
      queue_item(make_item(ModeNone, 8'hff, 8'hff));

      queue_item(make_item(ModeWrite, RegAudio, 8'hff));
      queue_item(make_mix(1'b1, 1'b1, '1, '0, 16'd0));

      set_frame_rate(1'b1);
      repeat (420) queue_item(random_item());
      set_frame_rate(1'b0);
      repeat (420) queue_item(random_item());
      set_frame_rate(1'b1);
      repeat (410) queue_item(random_item());

      wait (results_checked == items_queued);
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("stereo_dac_beeper_mixer_unit verification clean");
      end else begin
         $display("stereo_dac_beeper_mixer_unit verification failed");
      end
      $finish;
   end

endmodule
